// File: rtl/core/e2q_pkg.sv
// Shared constants, types and tables for the Euler-to-quaternion core.
package e2q_pkg;

  localparam int unsigned ResultFracBits = 14;
  localparam int unsigned TrigFrac       = 30;
  localparam int unsigned Stages         = 16;
  localparam int unsigned AngW           = 26;
  localparam int unsigned TrigW          = 33;
  localparam int unsigned InW            = 16;
  localparam int unsigned OutW           = 16;
  localparam int unsigned IdxW           = 4;
  localparam int unsigned ProdW          = 64;
  localparam int unsigned SumW           = 66;

  localparam logic signed [TrigW-1:0] CordicGain = 33'sd652032874;
  localparam logic signed [16:0] HalfTurnQ7 = 17'sd23040;
  localparam logic signed [16:0] FullTurnQ7 = 17'sd46080;
  localparam logic signed [AngW-1:0] QuarterTurn = 26'sd5898240;
  localparam logic signed [AngW-1:0] HalfTurn = 26'sd11796480;

  // One angle lane of a cell.
  typedef struct packed {
    logic signed [AngW-1:0]  a;
    logic signed [TrigW-1:0] x;
    logic signed [TrigW-1:0] y;
    logic                    neg_cos;
  } lane_t;

  typedef struct packed {
    lane_t roll;
    lane_t pitch;
    lane_t yaw;
  } cell_t;

  function automatic logic signed [AngW-1:0] atan_deg(input logic [IdxW-1:0] idx);
    logic signed [AngW-1:0] r;
    case (idx)
      4'd0:    r = 26'sd2949120;
      4'd1:    r = 26'sd1740967;
      4'd2:    r = 26'sd919879;
      4'd3:    r = 26'sd466945;
      4'd4:    r = 26'sd234379;
      4'd5:    r = 26'sd117304;
      4'd6:    r = 26'sd58666;
      4'd7:    r = 26'sd29335;
      4'd8:    r = 26'sd14668;
      4'd9:    r = 26'sd7334;
      4'd10:   r = 26'sd3667;
      4'd11:   r = 26'sd1833;
      4'd12:   r = 26'sd917;
      4'd13:   r = 26'sd458;
      4'd14:   r = 26'sd229;
      4'd15:   r = 26'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Wrap the half angle, scale it, and fold it into +-90 degrees.
  function automatic lane_t lane_init(input logic signed [InW-1:0] raw);
    logic signed [16:0] h;
    logic signed [AngW-1:0] a;
    lane_t l;
    h = 17'(raw);
    if (h >= HalfTurnQ7) h = h - FullTurnQ7;
    else if (h < -HalfTurnQ7) h = h + FullTurnQ7;
    a = AngW'(h) <<< 9;
    l.neg_cos = 1'b0;
    if (a > QuarterTurn) begin
      a = HalfTurn - a;
      l.neg_cos = 1'b1;
    end else if (a < -QuarterTurn) begin
      a = -HalfTurn - a;
      l.neg_cos = 1'b1;
    end
    l.a = a;
    l.x = CordicGain;
    l.y = '0;
    return l;
  endfunction

endpackage

// File: rtl/core/e2q_cell.sv
// One CORDIC rotation cell for three angle lanes.
module e2q_cell #(
  parameter int unsigned Shift = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  e2q_pkg::cell_t     data_i,
  output logic               valid_o,
  output e2q_pkg::cell_t     data_o
);

  localparam logic [e2q_pkg::IdxW-1:0] Idx = e2q_pkg::IdxW'(Shift);

  function automatic e2q_pkg::lane_t rotate(input e2q_pkg::lane_t l);
    e2q_pkg::lane_t r;
    r = l;
    if (!l.a[e2q_pkg::AngW-1]) begin
      r.x = l.x - (l.y >>> Shift);
      r.y = l.y + (l.x >>> Shift);
      r.a = l.a - e2q_pkg::atan_deg(Idx);
    end else begin
      r.x = l.x + (l.y >>> Shift);
      r.y = l.y - (l.x >>> Shift);
      r.a = l.a + e2q_pkg::atan_deg(Idx);
    end
    return r;
  endfunction

  e2q_pkg::cell_t data_d;
  logic           valid_q;
  e2q_pkg::cell_t data_q;

  // Rotate all three lanes by one micro-step.
  always_comb begin
    data_d.roll  = rotate(data_i.roll);
    data_d.pitch = rotate(data_i.pitch);
    data_d.yaw   = rotate(data_i.yaw);
  end

  // Advance when the chain moves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/core/e2q_combine.sv
// Product stages forming the quaternion from half-angle cosines and sines.
module e2q_combine #(
  parameter int unsigned ResultFracBits = e2q_pkg::ResultFracBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  e2q_pkg::cell_t                     data_i,
  output logic                               valid_o,
  output logic signed [e2q_pkg::OutW-1:0]    quat_w_o,
  output logic signed [e2q_pkg::OutW-1:0]    quat_x_o,
  output logic signed [e2q_pkg::OutW-1:0]    quat_y_o,
  output logic signed [e2q_pkg::OutW-1:0]    quat_z_o
);

  localparam int unsigned TW = e2q_pkg::TrigW;
  localparam int unsigned PW = e2q_pkg::ProdW;
  localparam int unsigned SW = e2q_pkg::SumW;
  localparam int unsigned Sh = 2 * e2q_pkg::TrigFrac - ResultFracBits;
  localparam logic signed [SW-1:0] Lim  = SW'(1) <<< ResultFracBits;
  localparam logic signed [SW-1:0] Half = SW'(1) <<< (Sh - 1);

  function automatic logic signed [e2q_pkg::OutW-1:0] finish(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + Half) >>> Sh;
    if (r > Lim) r = Lim;
    if (r < -Lim) r = -Lim;
    return r[e2q_pkg::OutW-1:0];
  endfunction

  // Stage 1: apply the cosine sign fold, register trig values.
  logic signed [TW-1:0] cx_q, sx_q, cy_q, sy_q, cz_q, sz_q;
  logic signed [TW-1:0] cz2_q, sz2_q;
  logic signed [TW-1:0] cxcy_q, sxsy_q, sxcy_q, cxsy_q;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q, p6_q, p7_q;
  logic signed [PW-1:0] m0, m1, m2, m3;
  logic [3:0] v_q;
  logic signed [e2q_pkg::OutW-1:0] w_q, x_q, y_q, z_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q <= data_i.roll.neg_cos  ? -data_i.roll.x  : data_i.roll.x;
      sx_q <= data_i.roll.y;
      cy_q <= data_i.pitch.neg_cos ? -data_i.pitch.x : data_i.pitch.x;
      sy_q <= data_i.pitch.y;
      cz_q <= data_i.yaw.neg_cos   ? -data_i.yaw.x   : data_i.yaw.x;
      sz_q <= data_i.yaw.y;
    end
  end

  // Stage 2: pairwise products floored back to 30 fraction bits.
  assign m0 = PW'(cx_q) * PW'(cy_q);
  assign m1 = PW'(sx_q) * PW'(sy_q);
  assign m2 = PW'(sx_q) * PW'(cy_q);
  assign m3 = PW'(cx_q) * PW'(sy_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cxcy_q <= TW'(m0 >>> e2q_pkg::TrigFrac);
      sxsy_q <= TW'(m1 >>> e2q_pkg::TrigFrac);
      sxcy_q <= TW'(m2 >>> e2q_pkg::TrigFrac);
      cxsy_q <= TW'(m3 >>> e2q_pkg::TrigFrac);
      cz2_q  <= cz_q;
      sz2_q  <= sz_q;
    end
  end

  // Stage 3: triple products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= PW'(cxcy_q) * PW'(cz2_q);
      p1_q <= PW'(sxsy_q) * PW'(sz2_q);
      p2_q <= PW'(sxcy_q) * PW'(cz2_q);
      p3_q <= PW'(cxsy_q) * PW'(sz2_q);
      p4_q <= PW'(cxsy_q) * PW'(cz2_q);
      p5_q <= PW'(sxcy_q) * PW'(sz2_q);
      p6_q <= PW'(cxcy_q) * PW'(sz2_q);
      p7_q <= PW'(sxsy_q) * PW'(cz2_q);
    end
  end

  // Stage 4: sum, round and saturate.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q <= finish(SW'(p0_q) + SW'(p1_q));
      x_q <= finish(SW'(p2_q) - SW'(p3_q));
      y_q <= finish(SW'(p4_q) + SW'(p5_q));
      z_q <= finish(SW'(p6_q) - SW'(p7_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  assign valid_o  = v_q[3];
  assign quat_w_o = w_q;
  assign quat_x_o = x_q;
  assign quat_y_o = y_q;
  assign quat_z_o = z_q;

endmodule

// File: rtl/core/euler_to_quaternion_core.sv
// Top level: Euler angles to unit quaternion, CORDIC cell chain plus products.
//
//   channel | direction | fields                          | handshake
//   in      | input     | roll_deg, pitch_deg, yaw_deg    | in_valid_i / in_stall_o
//   out     | output    | quat_w, quat_x, quat_y, quat_z  | out_valid_o / out_stall_i
//
// One item per cycle while the output is not stalled; the pipeline is the input
// register, 16 CORDIC cells, four product stages and the output register.
// Reset clears only valid bits. While the output is stalled and holding an
// item, the whole pipeline freezes; empty slots stay where they are.
module euler_to_quaternion_core #(
  parameter int unsigned ResultFracBits = e2q_pkg::ResultFracBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [e2q_pkg::InW-1:0]  roll_deg_i,
  input  logic signed [e2q_pkg::InW-1:0]  pitch_deg_i,
  input  logic signed [e2q_pkg::InW-1:0]  yaw_deg_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [e2q_pkg::OutW-1:0] quat_w_o,
  output logic signed [e2q_pkg::OutW-1:0] quat_x_o,
  output logic signed [e2q_pkg::OutW-1:0] quat_y_o,
  output logic signed [e2q_pkg::OutW-1:0] quat_z_o
);

  localparam int unsigned N = e2q_pkg::Stages;

  logic en;
  logic in_v_q;
  e2q_pkg::cell_t in_q;
  logic           chain_v [N+1];
  e2q_pkg::cell_t chain_d [N+1];
  logic comb_v;
  logic signed [e2q_pkg::OutW-1:0] w, x, y, z;
  logic out_v_q;
  logic signed [e2q_pkg::OutW-1:0] w_q, x_q, y_q, z_q;

  // Move whenever the output slot is free or being taken.
  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  // Register the prepared lanes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q.roll  <= e2q_pkg::lane_init(roll_deg_i);
      in_q.pitch <= e2q_pkg::lane_init(pitch_deg_i);
      in_q.yaw   <= e2q_pkg::lane_init(yaw_deg_i);
    end
  end

  assign chain_v[0] = in_v_q;
  assign chain_d[0] = in_q;

  // Chain of CORDIC cells.
  for (genvar g = 0; g < N; g++) begin : g_cell
    e2q_cell #(.Shift(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_v[g]),
      .data_i  (chain_d[g]),
      .valid_o (chain_v[g+1]),
      .data_o  (chain_d[g+1])
    );
  end

  e2q_combine #(.ResultFracBits(ResultFracBits)) u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (chain_v[N]),
    .data_i   (chain_d[N]),
    .valid_o  (comb_v),
    .quat_w_o (w),
    .quat_x_o (x),
    .quat_y_o (y),
    .quat_z_o (z)
  );

  // Output register; hold while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= comb_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q <= w;
      x_q <= x;
      y_q <= y;
      z_q <= z;
    end
  end

  assign out_valid_o = out_v_q;
  assign quat_w_o    = w_q;
  assign quat_x_o    = x_q;
  assign quat_y_o    = y_q;
  assign quat_z_o    = z_q;

  // Stall input exactly when a held result is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not track output blocking");

  // A blocked result stays put (checked on quat_w and quat_z).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(quat_w_o) && $stable(quat_z_o))
    else $error("blocked result changed");

  // quat_w stays within +-1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (quat_w_o <= 16'sd16384) && (quat_w_o >= -16'sd16384))
    else $error("quat_w out of range");

endmodule
